[hdl/two_stack_fifo_queue_macros.svh]
// Assertion macros shared by the two-stack queue RTL.
// Each macro expands to one labeled concurrent assertion with an $error report.
`ifndef TWO_STACK_FIFO_QUEUE_MACROS_SVH
`define TWO_STACK_FIFO_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSFQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TSFQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/tsfq_pkg.sv]
// Package for the two-stack queue: payload structs, codes and sequencer states.
// It has no dependencies; tsfq_ram and two_stack_fifo_queue import it.
package tsfq_pkg;

	typedef logic signed [31:0] word_t;

	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	localparam word_t MOST_NEG = 32'sh8000_0000;
	localparam word_t WORD_ZERO = 32'sh0000_0000;

	typedef struct packed {
		logic  op;
		word_t value;
	} req_t;

	typedef struct packed {
		word_t      data;
		logic [1:0] status;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_XFER,
		S_PUSH,
		S_POP,
		S_POPWAIT,
		S_REPLY
	} state_t;

endpackage

[hdl/tsfq_ram.sv]
// Stack storage for the two-stack queue: one write port and one registered read port.
// Depends on tsfq_pkg for the word type.
module tsfq_ram #(
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  tsfq_pkg::word_t     wdata,
	input  logic                re,
	input  logic [AW-1:0]       raddr,
	output tsfq_pkg::word_t     rdata
);
	import tsfq_pkg::*;

	word_t mem_q [DEPTH];
	word_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hdl/two_stack_fifo_queue.sv]
// Enqueue steps through PUSH and REPLY, dequeue through POP, POPWAIT and REPLY, and a dropped
// enqueue or an empty dequeue goes straight to REPLY. When the item first has to turn the stacks
// over, an XFER state comes first and moves the n stored words, one per cycle, through the
// registered read port of the source stack.
// One item is in work at a time; req_ready is high only while the sequencer is idle.
// Reset clears both word counts, the sequencer and the response valid; stack storage is
// not cleared and is only ever read below the current count.
module two_stack_fifo_queue #(
	parameter int DEPTH = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  tsfq_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output tsfq_pkg::rsp_t rsp
);
	import tsfq_pkg::*;

	`include "two_stack_fifo_queue_macros.svh"

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] CNT_ONE   = CW'(1);
	localparam logic [CW-1:0] CNT_ZERO  = CW'(0);
	localparam logic [CW:0]   DEPTH_EXT = (CW + 1)'(DEPTH);

	state_t state_q, state_d;

	logic          op_q;
	word_t         val_q;
	logic          pend_q, pend_d;
	logic [CW-1:0] in_cnt_q, in_cnt_d;
	logic [CW-1:0] out_cnt_q, out_cnt_d;
	word_t         res_data_q;
	logic [1:0]    res_status_q;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	logic          accept;
	logic [CW:0]   total;
	logic          full;
	logic          empty;
	logic          rsp_load;
	logic [CW-1:0] src_cnt;
	logic [CW-1:0] in_top, out_top;

	logic          in_we, in_re, out_we, out_re;
	logic [AW-1:0] in_waddr, in_raddr, out_waddr, out_raddr;
	word_t         in_wdata, out_wdata, in_rdata, out_rdata;

	tsfq_ram #(.DEPTH(DEPTH), .AW(AW)) u_in_stack (
		.clk   (clk),
		.we    (in_we),
		.waddr (in_waddr),
		.wdata (in_wdata),
		.re    (in_re),
		.raddr (in_raddr),
		.rdata (in_rdata)
	);

	tsfq_ram #(.DEPTH(DEPTH), .AW(AW)) u_out_stack (
		.clk   (clk),
		.we    (out_we),
		.waddr (out_waddr),
		.wdata (out_wdata),
		.re    (out_re),
		.raddr (out_raddr),
		.rdata (out_rdata)
	);

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign total     = {1'b0, in_cnt_q} + {1'b0, out_cnt_q};
	assign full      = (total >= DEPTH_EXT);
	assign empty     = (in_cnt_q == CNT_ZERO) && (out_cnt_q == CNT_ZERO);
	assign rsp_load  = (state_q == S_REPLY) && (!rsp_valid_q || rsp_ready);
	// A dequeue moves words from the enqueue stack, an enqueue moves them back.
	assign src_cnt   = (op_q == OP_DEQ) ? in_cnt_q : out_cnt_q;
	assign in_top    = in_cnt_q - CNT_ONE;
	assign out_top   = out_cnt_q - CNT_ONE;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req.op == OP_ENQ) begin
						if (full) begin
							state_d = S_REPLY;
						end else if (in_cnt_q == CNT_ZERO && out_cnt_q != CNT_ZERO) begin
							state_d = S_XFER;
						end else begin
							state_d = S_PUSH;
						end
					end else begin
						if (empty) begin
							state_d = S_REPLY;
						end else if (out_cnt_q == CNT_ZERO) begin
							state_d = S_XFER;
						end else begin
							state_d = S_POP;
						end
					end
				end
			end
			S_XFER: begin
				if (src_cnt == CNT_ZERO) begin
					state_d = (op_q == OP_DEQ) ? S_POP : S_PUSH;
				end
			end
			S_PUSH:    state_d = S_REPLY;
			S_POP:     state_d = S_POPWAIT;
			S_POPWAIT: state_d = S_REPLY;
			S_REPLY: begin
				if (rsp_load) begin
					state_d = S_IDLE;
				end
			end
			default:   state_d = S_IDLE;
		endcase
	end

	// Datapath controls: stack ports and count updates.
	always_comb begin
		in_we     = 1'b0;
		in_re     = 1'b0;
		out_we    = 1'b0;
		out_re    = 1'b0;
		in_waddr  = in_cnt_q[AW-1:0];
		out_waddr = out_cnt_q[AW-1:0];
		in_raddr  = in_top[AW-1:0];
		out_raddr = out_top[AW-1:0];
		in_wdata  = out_rdata;
		out_wdata = in_rdata;
		in_cnt_d  = in_cnt_q;
		out_cnt_d = out_cnt_q;
		pend_d    = 1'b0;
		unique case (state_q)
			S_XFER: begin
				// Read the source top this cycle, write the word read last cycle.
				if (op_q == OP_DEQ) begin
					if (in_cnt_q != CNT_ZERO) begin
						in_re    = 1'b1;
						in_cnt_d = in_cnt_q - CNT_ONE;
						pend_d   = 1'b1;
					end
					if (pend_q) begin
						out_we    = 1'b1;
						out_cnt_d = out_cnt_q + CNT_ONE;
					end
				end else begin
					if (out_cnt_q != CNT_ZERO) begin
						out_re    = 1'b1;
						out_cnt_d = out_cnt_q - CNT_ONE;
						pend_d    = 1'b1;
					end
					if (pend_q) begin
						in_we    = 1'b1;
						in_cnt_d = in_cnt_q + CNT_ONE;
					end
				end
			end
			S_PUSH: begin
				in_we    = 1'b1;
				in_wdata = val_q;
				in_cnt_d = in_cnt_q + CNT_ONE;
			end
			S_POP: begin
				out_re    = 1'b1;
				out_cnt_d = out_cnt_q - CNT_ONE;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pend_q      <= 1'b0;
			in_cnt_q    <= CNT_ZERO;
			out_cnt_q   <= CNT_ZERO;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			pend_q    <= pend_d;
			in_cnt_q  <= in_cnt_d;
			out_cnt_q <= out_cnt_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= req.op;
			val_q <= req.value;
			if (req.op == OP_ENQ) begin
				res_data_q   <= WORD_ZERO;
				res_status_q <= full ? STATUS_FULL : STATUS_OK;
			end else begin
				res_data_q   <= empty ? MOST_NEG : WORD_ZERO;
				res_status_q <= empty ? STATUS_EMPTY : STATUS_OK;
			end
		end else if (state_q == S_POPWAIT) begin
			res_data_q <= out_rdata;
		end
		if (rsp_load) begin
			rsp_q.data   <= res_data_q;
			rsp_q.status <= res_status_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`TSFQ_ASSERT_SAME(a_total_bound, clk, arst_n, 1'b1, total <= DEPTH_EXT, "queue holds more than DEPTH words")
	`TSFQ_ASSERT_SAME(a_one_stack_idle, clk, arst_n, state_q == S_IDLE, in_cnt_q == CNT_ZERO || out_cnt_q == CNT_ZERO, "both stacks hold words while idle")
	`TSFQ_ASSERT_SAME(a_pop_nonempty, clk, arst_n, state_q == S_POP, out_cnt_q != CNT_ZERO, "pop issued on an empty dequeue stack")
	`TSFQ_ASSERT_SAME(a_push_room, clk, arst_n, state_q == S_PUSH, !full && out_cnt_q == CNT_ZERO, "push issued without room or before the turnover finished")
	`TSFQ_ASSERT_SAME(a_empty_data, clk, arst_n, rsp_valid_q && rsp_q.status == STATUS_EMPTY, rsp_q.data == MOST_NEG, "empty dequeue response carries wrong data")

endmodule
